// ----- rtl/tcw_pkg.sv -----
// Shared types, constants and the address helper of the text console writer.
// No dependencies; every other console module but tcw_ram imports this package.
package tcw_pkg;

  localparam int ROWS   = 25;
  localparam int COLS   = 80;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = ATTR_W + CHAR_W;

  localparam int TAB_SPACES = 5;
  localparam int TAB_CNT_W  = 3;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_ATTR = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUT,
    ST_TAB,
    ST_FILL,
    ST_READ,
    ST_READ_DATA,
    ST_DONE
  } tcw_state_t;

  typedef struct packed {
    logic              command;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] attribute;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } tcw_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } tcw_result_t;

  // The screen is a ring of rows: logical row r lives in physical row
  // (r + base) mod ROWS, so a scroll only moves the base and refills one row.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] base);
    logic [ROW_W:0] prow;
    prow = {1'b0, row} + {1'b0, base};
    if (prow >= (ROW_W+1)'(ROWS)) begin
      prow = prow - (ROW_W+1)'(ROWS);
    end
    return ADDR_W'(prow) * ADDR_W'(COLS) + ADDR_W'(col);
  endfunction

endpackage

// ----- rtl/tcw_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the screen cell store.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tcw_apb_regs.sv -----
// APB configuration register block of the text console writer.
// Holds the default attribute; depends on tcw_pkg.
module tcw_apb_regs
  import tcw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [ATTR_W-1:0]     default_attr
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_fire;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1 -: REG_IDX_W];
  assign wr_fire = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= ATTR_RESET;
    end else if (wr_fire && reg_idx == REG_DEFAULT_ATTR) begin
      default_attr <= pwdata[ATTR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_DEFAULT_ATTR: prdata = APB_DATA_W'(default_attr);
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- rtl/tcw_engine.sv -----
// Command sequencer of the text console writer: cursor, row ring base,
// clearing pass, scroll fill and the read/modify traffic to the cell RAM.
// Depends on tcw_pkg.
module tcw_engine
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcw_item_t         in_item,
  input  logic [ATTR_W-1:0] default_attr,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [CELL_W-1:0] ram_wdata,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [CELL_W-1:0] ram_rdata,
  output logic              res_valid,
  input  logic              res_ready,
  output tcw_result_t       res
);

  tcw_state_t           state, state_next;
  logic [ROW_W-1:0]     cur_row, cur_row_next;
  logic [COL_W-1:0]     cur_col, cur_col_next;
  logic [ROW_W-1:0]     base_row, base_row_next;
  logic [ADDR_W-1:0]    clr_addr, clr_addr_next;
  logic [COL_W-1:0]     fill_col, fill_col_next;
  logic [TAB_CNT_W-1:0] tab_cnt, tab_cnt_next;
  logic                 scrolled, scrolled_next;
  logic [CELL_W-1:0]    cell_value, cell_value_next;
  tcw_item_t            item, item_next;

  logic                 in_fire;
  logic [ATTR_W-1:0]    attr_eff;
  logic [CELL_W-1:0]    space_cell;
  logic [ROW_W-1:0]     base_inc;
  logic [COL_W:0]       adv_col_sum;
  logic                 adv_wrap;
  logic [ROW_W:0]       adv_row_sum;
  logic                 adv_scroll;
  logic [ROW_W-1:0]     adv_row;
  logic [COL_W-1:0]     adv_col;
  logic [ROW_W:0]       lf_row_sum;
  logic                 lf_scroll;
  logic [ROW_W-1:0]     bs_row;
  logic [COL_W-1:0]     bs_col;
  logic                 in_range;

  assign in_fire    = in_valid && in_ready;
  assign attr_eff   = (item.attribute == '0) ? default_attr : item.attribute;
  assign space_cell = {default_attr, CH_SPACE};
  assign base_inc   = (base_row == ROW_W'(ROWS - 1)) ? '0 : base_row + 1'b1;

  // One store-and-advance step from the current cursor.
  assign adv_col_sum = {1'b0, cur_col} + 1'b1;
  assign adv_wrap    = (adv_col_sum == (COL_W+1)'(COLS));
  assign adv_col     = adv_wrap ? '0 : adv_col_sum[COL_W-1:0];
  assign adv_row_sum = {1'b0, cur_row} + {{ROW_W{1'b0}}, adv_wrap};
  assign adv_scroll  = (adv_row_sum == (ROW_W+1)'(ROWS));
  assign adv_row     = adv_scroll ? ROW_W'(ROWS - 1) : adv_row_sum[ROW_W-1:0];

  assign lf_row_sum = {1'b0, cur_row} + 1'b1;
  assign lf_scroll  = (lf_row_sum == (ROW_W+1)'(ROWS));

  assign bs_col = (cur_col == '0) ? COL_W'(COLS - 1) : cur_col - 1'b1;
  assign bs_row = (cur_col == '0) ? cur_row - 1'b1 : cur_row;

  assign in_range = (in_item.read_row < ROW_W'(ROWS)) && (in_item.read_col < COL_W'(COLS));

  always_comb begin
    state_next      = state;
    cur_row_next    = cur_row;
    cur_col_next    = cur_col;
    base_row_next   = base_row;
    clr_addr_next   = clr_addr;
    fill_col_next   = fill_col;
    tab_cnt_next    = tab_cnt;
    scrolled_next   = scrolled;
    cell_value_next = cell_value;
    item_next       = item;
    in_ready        = 1'b0;
    res_valid       = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = cell_addr(cur_row, cur_col, base_row);
    ram_wdata       = space_cell;
    ram_raddr       = cell_addr(item.read_row, item.read_col, base_row);

    case (state)
      ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        ram_wdata     = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          item_next       = in_item;
          scrolled_next   = 1'b0;
          cell_value_next = '0;
          if (in_item.command == CMD_PUT) begin
            state_next = ST_PUT;
          end else if (in_range) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_DONE;
          end
        end
      end

      ST_PUT: begin
        state_next = ST_DONE;
        case (item.char_code)
          CH_BS: begin
            if (cur_row != '0 || cur_col != '0) begin
              ram_we       = 1'b1;
              ram_waddr    = cell_addr(bs_row, bs_col, base_row);
              ram_wdata    = {attr_eff, CH_SPACE};
              cur_row_next = bs_row;
              cur_col_next = bs_col;
            end
          end
          CH_LF: begin
            cur_col_next = '0;
            if (lf_scroll) begin
              cur_row_next  = ROW_W'(ROWS - 1);
              base_row_next = base_inc;
              fill_col_next = '0;
              scrolled_next = 1'b1;
              state_next    = ST_FILL;
            end else begin
              cur_row_next = lf_row_sum[ROW_W-1:0];
            end
          end
          CH_CR: begin
            cur_col_next = '0;
          end
          CH_TAB: begin
            tab_cnt_next = '0;
            state_next   = ST_TAB;
          end
          default: begin
            ram_we       = 1'b1;
            ram_wdata    = {attr_eff, item.char_code};
            cur_row_next = adv_row;
            cur_col_next = adv_col;
            if (adv_scroll) begin
              base_row_next = base_inc;
              fill_col_next = '0;
              scrolled_next = 1'b1;
              state_next    = ST_FILL;
            end
          end
        endcase
      end

      ST_TAB: begin
        ram_we       = 1'b1;
        cur_row_next = adv_row;
        cur_col_next = adv_col;
        tab_cnt_next = tab_cnt + 1'b1;
        if (adv_scroll) begin
          base_row_next = base_inc;
          fill_col_next = '0;
          scrolled_next = 1'b1;
          state_next    = ST_FILL;
        end else if (tab_cnt_next == TAB_CNT_W'(TAB_SPACES)) begin
          state_next = ST_DONE;
        end
      end

      ST_FILL: begin
        // Base already points past the old top row, which is now the bottom.
        ram_we        = 1'b1;
        ram_waddr     = cell_addr(ROW_W'(ROWS - 1), fill_col, base_row);
        fill_col_next = fill_col + 1'b1;
        if (fill_col == COL_W'(COLS - 1)) begin
          if (item.char_code == CH_TAB && tab_cnt != TAB_CNT_W'(TAB_SPACES)) begin
            state_next = ST_TAB;
          end else begin
            state_next = ST_DONE;
          end
        end
      end

      ST_READ: begin
        state_next = ST_READ_DATA;
      end

      ST_READ_DATA: begin
        cell_value_next = ram_rdata;
        state_next      = ST_DONE;
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign res.cursor_row = cur_row;
  assign res.cursor_col = cur_col;
  assign res.cell_value = cell_value;
  assign res.scrolled   = scrolled;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cur_row  <= '0;
      cur_col  <= '0;
      base_row <= '0;
      clr_addr <= '0;
      fill_col <= '0;
      tab_cnt  <= '0;
      scrolled <= 1'b0;
    end else begin
      state    <= state_next;
      cur_row  <= cur_row_next;
      cur_col  <= cur_col_next;
      base_row <= base_row_next;
      clr_addr <= clr_addr_next;
      fill_col <= fill_col_next;
      tab_cnt  <= tab_cnt_next;
      scrolled <= scrolled_next;
    end
  end

  always_ff @(posedge clk) begin
    item       <= item_next;
    cell_value <= cell_value_next;
  end

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (cur_row < ROW_W'(ROWS) && cur_col < COL_W'(COLS)))
    else $error("cursor left the screen");

  a_base_in_ring: assert property (@(posedge clk) disable iff (rst)
    base_row < ROW_W'(ROWS))
    else $error("row ring base out of range");

  a_fill_on_bottom: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> (cur_row == ROW_W'(ROWS - 1)))
    else $error("scroll fill with cursor off the bottom row");

  a_read_no_scroll: assert property (@(posedge clk) disable iff (rst)
    (res_valid && item.command == CMD_READ) |-> !scrolled)
    else $error("read reports a scroll");

  a_no_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> !ram_we)
    else $error("cell write while taking an item");

endmodule

// ----- rtl/text_console_char_writer.sv -----
// Text console writer: put one character or control code, or read one cell, per
// item. Each scroll refills the bottom row with spaces in the default attribute.
// The result sits in an output register, so a new item is taken while it waits.
// After rst the cell RAM is cleared to zero, one cell a cycle, with s_tready low;
// the cursor goes home and the default attribute returns to 7.
module text_console_char_writer
  import tcw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [7:0] char_code, [15:8] attribute, [20:16] read_row, [27:21] read_col
  input  logic [31:0]           s_tdata,
  // [0] command
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [4:0] cursor_row, [11:5] cursor_col, [27:12] cell_value, [28] scrolled
  output logic [31:0]           m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  tcw_item_t         in_item;
  tcw_result_t       res;
  logic              res_valid;
  logic              res_ready;
  logic [ATTR_W-1:0] default_attr;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;
  tcw_result_t       out_reg;

  assign in_item.command   = s_tuser;
  assign in_item.char_code = s_tdata[7:0];
  assign in_item.attribute = s_tdata[15:8];
  assign in_item.read_row  = s_tdata[20:16];
  assign in_item.read_col  = s_tdata[27:21];

  tcw_apb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .default_attr (default_attr)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_item      (in_item),
    .default_attr (default_attr),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_reg <= res;
    end
  end

  assign m_tdata = {3'b000, out_reg.scrolled, out_reg.cell_value,
                    out_reg.cursor_col, out_reg.cursor_row};

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the text console writer: a behavioral screen
// predictor checks every result item. Depends on tcw_pkg and the writer RTL.
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  typedef enum int {RX_ALWAYS, RX_LIGHT, RX_PATTERN, RX_HEAVY} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  text_console_char_writer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Predicted screen contents, cursor and default attribute.
  logic [CELL_W-1:0] screen_model [CELLS];
  int unsigned       cursor_model = 0;
  logic [ATTR_W-1:0] attr_model = ATTR_RESET;

  tcw_result_t expected_results [$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          reads_sent = 0;
  int          scrolls_seen = 0;
  int          results_checked = 0;
  int          attr_settings = 0;
  int          burst_left = 0;

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      screen_model[i] = '0;
    end
  end

  function automatic bit scroll_screen();
    if (cursor_model < CELLS) return 1'b0;
    for (int i = 0; i < CELLS - COLS; i++) begin
      screen_model[i] = screen_model[i + COLS];
    end
    for (int i = CELLS - COLS; i < CELLS; i++) begin
      screen_model[i] = {attr_model, CH_SPACE};
    end
    cursor_model -= COLS;
    return 1'b1;
  endfunction

  function automatic bit store_cell(input logic [CELL_W-1:0] cell_data);
    if (cursor_model < CELLS) screen_model[cursor_model] = cell_data;
    cursor_model++;
    return scroll_screen();
  endfunction

  function automatic tcw_result_t predict_console(input tcw_item_t it);
    tcw_result_t       r;
    logic [ATTR_W-1:0] a;
    bit                sc;
    r = '0;
    sc = 1'b0;
    if (it.command == CMD_PUT) begin
      a = (it.attribute == '0) ? attr_model : it.attribute;
      case (it.char_code)
        CH_BS: begin
          if (cursor_model > 0) begin
            cursor_model--;
            screen_model[cursor_model] = {a, CH_SPACE};
          end
        end
        CH_LF: begin
          cursor_model += COLS;
          cursor_model -= cursor_model % COLS;
          sc = scroll_screen();
        end
        CH_CR: cursor_model -= cursor_model % COLS;
        CH_TAB: begin
          // Tab spaces always use the default attribute, whatever the item says.
          for (int k = 0; k < TAB_SPACES; k++) begin
            if (store_cell({attr_model, CH_SPACE})) sc = 1'b1;
          end
        end
        default: sc = store_cell({a, it.char_code});
      endcase
    end else if (it.read_row < ROWS && it.read_col < COLS) begin
      r.cell_value = screen_model[it.read_row * COLS + it.read_col];
    end
    r.cursor_row = ROW_W'(cursor_model / COLS);
    r.cursor_col = COL_W'(cursor_model % COLS);
    r.scrolled = sc;
    return r;
  endfunction

  function automatic tcw_item_t put_item(input logic [CHAR_W-1:0] code,
                                         input logic [ATTR_W-1:0] attr);
    tcw_item_t it;
    it = '0;
    it.command = CMD_PUT;
    it.char_code = code;
    it.attribute = attr;
    return it;
  endfunction

  function automatic tcw_item_t read_item(input int row, input int col);
    tcw_item_t it;
    it = '0;
    it.command = CMD_READ;
    it.read_row = ROW_W'(row);
    it.read_col = COL_W'(col);
    return it;
  endfunction

  // Text-like traffic; lf_pct and tab_pct steer how fast the cursor runs down.
  function automatic tcw_item_t random_text_item(input int lf_pct, input int tab_pct);
    tcw_item_t it;
    int        pick;
    it.command   = CMD_PUT;
    it.char_code = CHAR_W'($urandom);
    it.attribute = ($urandom_range(0, 3) == 0) ? '0 : ATTR_W'($urandom);
    it.read_row  = ROW_W'($urandom);
    it.read_col  = COL_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      it.command = CMD_READ;
      it.read_row = ($urandom_range(0, 9) == 0) ? ROW_W'($urandom) :
                    ROW_W'($urandom_range(0, ROWS - 1));
      it.read_col = ($urandom_range(0, 9) == 0) ? COL_W'($urandom) :
                    COL_W'($urandom_range(0, COLS - 1));
    end else if (pick < 18 + lf_pct) begin
      it.char_code = CH_LF;
    end else if (pick < 18 + lf_pct + tab_pct) begin
      it.char_code = CH_TAB;
    end else if (pick < 24 + lf_pct + tab_pct) begin
      it.char_code = CH_BS;
    end else if (pick < 28 + lf_pct + tab_pct) begin
      it.char_code = CH_CR;
    end
    return it;
  endfunction

  task automatic send_item(input tcw_item_t it);
    tcw_result_t r;
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, it.read_col, it.read_row, it.attribute, it.char_code};
    s_tuser  <= it.command;
    do @(posedge clk); while (!s_tready);
    r = predict_console(it);
    expected_results.push_back(r);
    items_sent++;
    if (it.command == CMD_READ) reads_sent++;
    if (r.scrolled) scrolls_seen++;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) :
                   $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_default_attr(input logic [ATTR_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * REG_DEFAULT_ATTR);
    // Upper data bits carry junk; only the low byte belongs to the register.
    pwdata  <= {(APB_DATA_W-ATTR_W)'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    attr_model = value;
    attr_settings++;
  endtask

  task automatic test_control_codes();
    send_item(put_item(CH_BS, 8'h00));
    send_item(put_item("A", 8'h00));
    send_item(put_item(8'hFF, 8'hFF));
    send_item(put_item(8'h00, 8'h80));
    send_item(put_item(CH_TAB, 8'h5A));
    send_item(put_item(CH_BS, 8'h1E));
    send_item(put_item(CH_BS, 8'h00));
    send_item(put_item(CH_CR, 8'h33));
    send_item(put_item(CH_LF, 8'h00));
    send_item(put_item(CH_LF, 8'hC3));
    send_item(put_item("Z", 8'h4F));
    send_item(put_item(CH_CR, 8'h00));
  endtask

  task automatic test_cell_reads();
    send_item(read_item(0, 0));
    send_item(read_item(0, 1));
    send_item(read_item(0, 2));
    send_item(read_item(0, 5));
    send_item(read_item(2, 0));
    send_item(read_item(ROWS - 1, COLS - 1));
    send_item(read_item(ROWS, 0));
    send_item(read_item(0, COLS));
    send_item(read_item(31, 127));
    send_item(read_item(ROWS - 1, COLS));
  endtask

  task automatic test_text_with_attribute(input logic [ATTR_W-1:0] attr, input int count);
    wait_drained();
    write_default_attr(attr);
    repeat (count) send_item(random_text_item(12, 8));
  endtask

  // Newline and tab heavy traffic drives the cursor to the bottom row and makes it scroll.
  task automatic test_scroll_stress(input logic [ATTR_W-1:0] attr, input int count);
    wait_drained();
    write_default_attr(attr);
    repeat (count) send_item(random_text_item(40, 20));
  endtask

  // Receiver stalls: the mode is picked at random as rx_count runs; one mode never stalls.
  rx_mode_t   rx_mode = RX_ALWAYS;
  logic [7:0] rx_pattern = 8'hFF;
  int         rx_count = 0;

  always @(posedge clk) begin
    rx_count <= rx_count + 1;
    if (rx_count % 50 == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_pattern <= 8'($urandom);
    end
    case (rx_mode)
      RX_ALWAYS:  m_tready <= 1'b1;
      RX_LIGHT:   m_tready <= ($urandom_range(0, 3) != 0);
      RX_PATTERN: m_tready <= rx_pattern[rx_count % 8];
      default:    m_tready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    tcw_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none actual %h", $time, m_tdata);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("cursor_row", 32'(want.cursor_row), 32'(m_tdata[4:0]));
        check_field("cursor_col", 32'(want.cursor_col), 32'(m_tdata[11:5]));
        check_field("cell_value", 32'(want.cell_value), 32'(m_tdata[27:12]));
        check_field("scrolled", 32'(want.scrolled), 32'(m_tdata[28]));
        check_field("padding", 32'd0, 32'(m_tdata[31:29]));
        results_checked++;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_control_codes();
    test_cell_reads();
    test_text_with_attribute(8'h00, 120);
    test_text_with_attribute(8'hFF, 120);
    test_scroll_stress(ATTR_W'($urandom_range(1, 254)), 160);
    test_text_with_attribute(ATTR_W'($urandom), 150);
    test_scroll_stress(ATTR_RESET, 130);
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d items (%0d cell reads, %0d scrolling puts) under %0d attribute settings,",
             items_sent, reads_sent, scrolls_seen, attr_settings + 1);
    $display("with %0d result items checked and %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Timeout with %0d result items outstanding.", expected_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_apb_regs.sv
rtl/tcw_engine.sv
rtl/text_console_char_writer.sv
tb/sv/tb_top.sv
